/* rtl/core/tmrp_pkg.sv */
// Shared types and constants for the tile median row profile unit.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package tmrp_pkg;
   localparam int MaxTiles = 32;
   localparam int MaxWidth = 4096;
   localparam int PixW = 16;
   localparam int ProfW = 17;
   localparam int CsrIdxW = 1;
   localparam int CsrDataW = 16;
   localparam int RowWidthW = 13;
   localparam int TileCountW = 6;
   localparam logic [CsrIdxW-1:0] RegRowWidth = 1'b0;
   localparam logic [CsrIdxW-1:0] RegTileCount = 1'b1;
   localparam logic [12:0] RowWidthReset = 13'd640;
   localparam logic [5:0] TileCountReset = 6'd8;

   typedef struct packed {
      logic clear;      // clear row state, start boundary computation
      logic accum;      // accumulate the held pixel
      logic edge_start; // advance to the next tile, start its right edge division
      logic fin_start;  // start end of row processing
   } cmd_type;

   typedef struct packed {
      logic edge_busy;
      logic need_adv;   // pixel column has passed the current boundary
      logic fin_done;
   } sts_type;
endpackage
`default_nettype wire

/* rtl/core/tmrp_datapath.sv */
// Datapath: tile accumulators, boundary divider, mean divider and sorted insert.
// Depends on tmrp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tmrp_datapath #(
   parameter int MAX_TILES = tmrp_pkg::MaxTiles,
   parameter int MAX_WIDTH = tmrp_pkg::MaxWidth
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire tmrp_pkg::cmd_type           cmd,
   output tmrp_pkg::sts_type                sts,
   input  wire logic [12:0]                 row_width,
   input  wire logic [5:0]                  tile_count,
   input  wire logic [tmrp_pkg::PixW-1:0]   pixel_value,
   input  wire logic                        pixel_valid,
   output logic [tmrp_pkg::ProfW-1:0]       profile_value,
   output logic                             row_usable
);
   localparam int TW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
   localparam int TCW = $clog2(MAX_TILES + 1);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int SW = tmrp_pkg::PixW + WW;
   localparam int PW = WW + TCW;

   logic [WW-1:0] w_eff;
   logic [TCW-1:0] t_eff;
   always_comb begin
      logic [TCW:0] t;
      if (row_width == 13'd0) w_eff = WW'(1);
      else if ({19'd0, row_width} > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
      else w_eff = WW'(row_width);
      if (tile_count == 6'd0) t = (TCW+1)'(1);
      else if ({26'd0, tile_count} > MAX_TILES) t = (TCW+1)'(MAX_TILES);
      else t = (TCW+1)'(tile_count);
      if ({{(32-TCW-1){1'b0}}, t} > {{(32-WW){1'b0}}, w_eff}) t = (TCW+1)'(w_eff);
      t_eff = TCW'(t);
   end

   logic [SW-1:0] sums_mem [MAX_TILES];
   logic [WW-1:0] cnts_mem [MAX_TILES];
   logic [MAX_TILES-1:0] live_ff;
   logic [WW-1:0] col_ff;
   logic [TW-1:0] tile_ff;
   logic [WW-1:0] bound_ff;

   // Boundary divider: (tile+1)*W / T, restoring, one bit a cycle.
   logic edge_busy_ff;
   logic [PW-1:0] eq_ff, er_ff;
   logic [$clog2(PW+1)-1:0] ecnt_ff;
   logic [PW:0] etrial;
   assign etrial = {er_ff, eq_ff[PW-1]} - {{(PW+1-TCW){1'b0}}, t_eff};

   // End of row: mean divider and sorted insertion.
   typedef enum logic [2:0] {F_IDLE, F_SCAN, F_DIV, F_INS, F_OUT, F_DONE} fst_type;
   fst_type fst_ff;
   logic [TW:0] fi_ff;
   logic [SW-1:0] dq_ff;
   logic [WW:0] dr_ff;
   logic [WW-1:0] dd_ff;
   logic [$clog2(SW+1)-1:0] dcnt_ff;
   logic [WW+1:0] dtrial;
   logic [tmrp_pkg::PixW-1:0] means_ff [MAX_TILES];
   logic [TW:0] n_ff;
   logic [MAX_TILES-1:0] gt;
   assign dtrial = {dr_ff, dq_ff[SW-1]} - {1'b0, dd_ff};

   always_comb begin
      for (int k = 0; k < MAX_TILES; k++)
         gt[k] = (k < n_ff) && (means_ff[k] > dq_ff[tmrp_pkg::PixW-1:0]);
   end

   assign sts.edge_busy = edge_busy_ff;
   assign sts.need_adv = (col_ff < w_eff) && ({1'b0, tile_ff} + 1'b1 < (TW+1)'(t_eff))
                         && (col_ff >= bound_ff);
   assign sts.fin_done = (fst_ff == F_DONE);

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         live_ff <= '0;
         col_ff <= '0;
         tile_ff <= '0;
      end else begin
         if (cmd.accum && col_ff < w_eff) begin
            if (pixel_valid) begin
               live_ff[tile_ff] <= 1'b1;
               sums_mem[tile_ff] <= (live_ff[tile_ff] ? sums_mem[tile_ff] : '0)
                                    + SW'(pixel_value);
               cnts_mem[tile_ff] <= (live_ff[tile_ff] ? cnts_mem[tile_ff] : '0) + 1'b1;
            end
            col_ff <= col_ff + 1'b1;
         end
         if (cmd.edge_start) tile_ff <= tile_ff + 1'b1;
      end
      if (reset) begin
         edge_busy_ff <= 1'b0;
      end else if (cmd.clear || cmd.edge_start) begin
         edge_busy_ff <= 1'b1;
         ecnt_ff <= '0;
         er_ff <= '0;
         eq_ff <= PW'(({{(32-TW){1'b0}}, cmd.clear ? TW'(0) : tile_ff} + 2) * w_eff)
                  - (cmd.clear ? PW'(w_eff) : '0);
      end else if (edge_busy_ff) begin
         if (!etrial[PW]) er_ff <= etrial[PW-1:0];
         else er_ff <= {er_ff[PW-2:0], eq_ff[PW-1]};
         eq_ff <= {eq_ff[PW-2:0], ~etrial[PW]};
         ecnt_ff <= ecnt_ff + 1'b1;
         if (ecnt_ff == ($clog2(PW+1))'(PW - 1)) begin
            edge_busy_ff <= 1'b0;
            bound_ff <= WW'({eq_ff[PW-2:0], ~etrial[PW]});
         end
      end
      if (reset) begin
         fst_ff <= F_IDLE;
      end else begin
         unique case (fst_ff)
            F_IDLE: if (cmd.fin_start) begin
               fst_ff <= F_SCAN;
               fi_ff <= '0;
               n_ff <= '0;
            end
            F_SCAN: begin
               if (fi_ff >= (TW+1)'(t_eff)) begin
                  fst_ff <= F_OUT;
               end else if (live_ff[fi_ff[TW-1:0]]) begin
                  dq_ff <= sums_mem[fi_ff[TW-1:0]];
                  dd_ff <= cnts_mem[fi_ff[TW-1:0]];
                  dr_ff <= '0;
                  dcnt_ff <= '0;
                  fst_ff <= F_DIV;
               end else begin
                  fi_ff <= fi_ff + 1'b1;
               end
            end
            F_DIV: begin
               if (!dtrial[WW+1]) dr_ff <= dtrial[WW:0];
               else dr_ff <= {dr_ff[WW-1:0], dq_ff[SW-1]};
               dq_ff <= {dq_ff[SW-2:0], ~dtrial[WW+1]};
               dcnt_ff <= dcnt_ff + 1'b1;
               if (dcnt_ff == ($clog2(SW+1))'(SW - 1)) fst_ff <= F_INS;
            end
            F_INS: begin
               for (int k = 0; k < MAX_TILES; k++) begin
                  if (gt[k] && k + 1 < MAX_TILES) means_ff[k+1] <= means_ff[k];
                  if ((k == 0 || !gt[k-1]) && (gt[k] || k == n_ff))
                     means_ff[k] <= dq_ff[tmrp_pkg::PixW-1:0];
               end
               n_ff <= n_ff + 1'b1;
               fi_ff <= fi_ff + 1'b1;
               fst_ff <= F_SCAN;
            end
            F_OUT: begin
               row_usable <= (n_ff != '0);
               if (n_ff == '0) profile_value <= '0;
               else if (n_ff[0])
                  profile_value <= {means_ff[n_ff[TW:1]], 1'b0};
               else
                  profile_value <= {1'b0, means_ff[n_ff[TW:1] - 1'b1]}
                                   + {1'b0, means_ff[n_ff[TW:1]]};
               fst_ff <= F_DONE;
            end
            F_DONE: fst_ff <= F_IDLE;
            default: fst_ff <= F_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (!reset && fst_ff == F_DIV)
         assert (dd_ff != '0) else $error("mean divider with zero count");
   end
   assert property (@(posedge clock) disable iff (reset)
      fst_ff == F_INS |=> n_ff == $past(n_ff) + 1'b1)
      else $error("insert did not grow list");
   assert property (@(posedge clock) disable iff (reset)
      fst_ff == F_OUT |=> fst_ff == F_DONE)
      else $error("output step lost");
   assert property (@(posedge clock) disable iff (reset)
      cmd.fin_start |-> fst_ff == F_IDLE)
      else $error("finish started while busy");
endmodule
`default_nettype wire

/* rtl/core/tmrp_ctrl.sv */
// Controller: sequences pixel accumulation, tile boundary advance and row close.
// Depends on tmrp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tmrp_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_fire,
   input  wire logic              req_last,
   input  wire logic              csr_fire,
   input  wire logic              rsp_fire,
   input  wire tmrp_pkg::sts_type sts,
   output tmrp_pkg::cmd_type      cmd,
   output logic                   req_ready,
   output logic                   rsp_valid,
   output logic                   load_pix
);
   typedef enum logic [2:0] {S_INIT, S_IDLE, S_ADV, S_ACC, S_FIN, S_OUT} state_type;
   state_type state_ff;
   logic last_ff;
   logic csr_pend_ff;

   // The row clear follows a register write in the next cycle so that the first
   // tile edge is computed from the updated registers.
   assign req_ready = (state_ff == S_IDLE) && !sts.edge_busy && !csr_pend_ff;
   assign rsp_valid = (state_ff == S_OUT);
   assign load_pix = req_fire;

   always_comb begin
      cmd = '0;
      cmd.clear = (state_ff == S_INIT) || csr_pend_ff || (rsp_fire);
      cmd.accum = (state_ff == S_ACC);
      cmd.edge_start = (state_ff == S_ADV) && !sts.edge_busy && sts.need_adv;
      cmd.fin_start = (state_ff == S_ACC) && last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         last_ff <= 1'b0;
         csr_pend_ff <= 1'b0;
      end else begin
         csr_pend_ff <= csr_fire;
         unique case (state_ff)
            S_INIT: state_ff <= S_IDLE;
            S_IDLE: if (req_fire) begin
               last_ff <= req_last;
               state_ff <= S_ADV;
            end
            S_ADV: if (!sts.edge_busy && !sts.need_adv) state_ff <= S_ACC;
            S_ACC: state_ff <= last_ff ? S_FIN : S_IDLE;
            S_FIN: if (sts.fin_done) state_ff <= S_OUT;
            S_OUT: if (rsp_fire) state_ff <= S_IDLE;
            default: state_ff <= S_INIT;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      req_fire |-> state_ff == S_IDLE)
      else $error("request taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      cmd.accum |-> !sts.edge_busy)
      else $error("accumulate during boundary update");
   assert property (@(posedge clock) disable iff (reset)
      sts.fin_done |-> state_ff == S_FIN)
      else $error("row close outside finish state");
endmodule
`default_nettype wire

/* rtl/core/tile_median_row_profile_unit.sv */
// Top level of the tile median row profile unit.
// Instantiates tmrp_ctrl and tmrp_datapath; depends on tmrp_pkg.
//
// Pixels enter on the req_ channel in row order, one request per pixel;
// tlast marks the last pixel of a row and tuser carries the valid-mask bit.
// Each pixel passes through the idle, advance and accumulate states, and
// waits for the bit-serial boundary divider when it crosses a tile boundary.
// At row end the tile means are formed by a bit-serial divider, with one
// division per non-empty tile, and inserted into a sorted list before the
// single result appears on rsp_. The result is held until the receiver
// takes it and no pixel is accepted meanwhile. After reset, after each
// result and after each csr_ write the row state clears and the first tile
// edge is computed, which holds req_tready low until the boundary divider
// finishes. Reset returns the registers to 640 pixels and 8 tiles.
`timescale 1ns / 1ps
`default_nettype none
module tile_median_row_profile_unit #(
   parameter int MAX_TILES = tmrp_pkg::MaxTiles,
   parameter int MAX_WIDTH = tmrp_pkg::MaxWidth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // pixel_value
   input  wire logic        req_tuser,  // pixel_valid
   input  wire logic        req_tlast,  // row_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // profile_value, zero fill
   output logic             rsp_tuser,  // row_usable
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [tmrp_pkg::CsrIdxW-1:0]  csr_index,
   input  wire logic [tmrp_pkg::CsrDataW-1:0] csr_data
);
   tmrp_pkg::cmd_type cmd;
   tmrp_pkg::sts_type sts;
   logic [12:0] row_width_ff;
   logic [5:0] tile_count_ff;
   logic [15:0] pix_ff;
   logic pval_ff;
   logic load_pix;
   logic [tmrp_pkg::ProfW-1:0] prof;
   logic usable;
   logic req_fire, rsp_fire, csr_fire;

   assign csr_ready = 1'b1;
   assign csr_fire = csr_valid;
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign rsp_tdata = {7'd0, prof};
   assign rsp_tuser = usable;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= tmrp_pkg::RowWidthReset;
         tile_count_ff <= tmrp_pkg::TileCountReset;
      end else if (csr_fire) begin
         unique case (csr_index)
            tmrp_pkg::RegRowWidth: row_width_ff <= csr_data[12:0];
            tmrp_pkg::RegTileCount: tile_count_ff <= csr_data[5:0];
            default: ;
         endcase
      end
      if (load_pix) begin
         pix_ff <= req_tdata;
         pval_ff <= req_tuser;
      end
   end

   tmrp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .req_last(req_tlast),
      .csr_fire(csr_fire), .rsp_fire(rsp_fire), .sts(sts), .cmd(cmd),
      .req_ready(req_tready), .rsp_valid(rsp_tvalid), .load_pix(load_pix)
   );

   tmrp_datapath #(.MAX_TILES(MAX_TILES), .MAX_WIDTH(MAX_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .row_width(row_width_ff), .tile_count(tile_count_ff),
      .pixel_value(pix_ff), .pixel_valid(pval_ff),
      .profile_value(prof), .row_usable(usable)
   );
endmodule
`default_nettype wire
